@@ rtl/sfe_pkg.sv @@
package sfe_pkg;

	localparam int MAX_BINS    = 512;
	localparam int MAX_DELAY   = 32;
	localparam int SAMPLE_BITS = 24;

	// Register field widths.
	localparam int GAIN_W      = 16;
	localparam int DELAY_CFG_W = 6;
	localparam int BINS_CFG_W  = 10;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	localparam int GAIN_RESET  = 58982;
	localparam int DELAY_RESET = 21;
	localparam int BINS_RESET  = 512;

	localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE  = CFG_IDX_W'(2);

	localparam int BIN_W   = $clog2(MAX_BINS);
	localparam int SLOT_W  = $clog2(MAX_DELAY);
	localparam int ADDR_W  = SLOT_W + BIN_W;
	localparam int PAIR_W  = 2 * SAMPLE_BITS;
	localparam int TDATA_W = ((PAIR_W + 7) / 8) * 8;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Address of one bin in the history and whether it closes its frame.
	typedef struct packed {
		addr_t addr;
		logic  last;
	} bin_tag_t;

	typedef struct packed {
		logic              en;
		addr_t             addr;
		logic [PAIR_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		sample_t re;
		sample_t im;
		logic    last;
		logic    clip;
	} result_t;

endpackage

@@ rtl/sfe_seq.sv @@
module sfe_seq
	import sfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	output logic [GAIN_W-1:0]     gain,
	output bin_tag_t              tag
);

	logic [GAIN_W-1:0] gain_q;
	logic [BIN_W-1:0]  last_bin_q;
	logic [SLOT_W-1:0] last_slot_q;
	logic [BIN_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;

	// Registers keep the clamped count minus one, ready for the frame-end compare.
	function automatic logic [BIN_W-1:0] bins_last(input logic [BINS_CFG_W-1:0] v);
		logic [BIN_W-1:0] r;
		priority if (32'(v) < 2) begin
			r = BIN_W'(1);
		end else if (32'(v) > MAX_BINS) begin
			r = BIN_W'(MAX_BINS - 1);
		end else begin
			r = BIN_W'(v - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] delay_last(input logic [DELAY_CFG_W-1:0] v);
		logic [SLOT_W-1:0] r;
		priority if (32'(v) < 1) begin
			r = '0;
		end else if (32'(v) > MAX_DELAY) begin
			r = SLOT_W'(MAX_DELAY - 1);
		end else begin
			r = SLOT_W'(v - 1'b1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_W'(GAIN_RESET);
			last_slot_q <= SLOT_W'(DELAY_RESET - 1);
			last_bin_q  <= BIN_W'(BINS_RESET - 1);
			pos_q       <= '0;
			slot_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ECHO_GAIN:    gain_q      <= cfg_data[GAIN_W-1:0];
					REG_DELAY_FRAMES: last_slot_q <= delay_last(cfg_data[DELAY_CFG_W-1:0]);
					REG_BINS_IN_USE:  last_bin_q  <= bins_last(cfg_data[BINS_CFG_W-1:0]);
					default: ;
				endcase
			end
			if (accept) begin
				if (tag.last) begin
					pos_q  <= '0;
					slot_q <= (slot_q >= last_slot_q) ? '0 : slot_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign gain      = gain_q;
	assign tag.addr  = {slot_q, pos_q};
	assign tag.last  = (pos_q >= last_bin_q);

endmodule

@@ rtl/sfe_store.sv @@
module sfe_store
	import sfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  addr_t             rd_addr,
	output logic [PAIR_W-1:0] rdata_s1,
	input  store_wr_t         wr,
	output logic              busy
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [PAIR_W-1:0] mem [DEPTH];
	logic              busy_q;
	addr_t             clr_addr_q;

	logic              we;
	addr_t             waddr;
	logic [PAIR_W-1:0] wdata;

	// After reset the whole history is swept to zero, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign we    = busy_q || wr.en;
	assign waddr = busy_q ? clr_addr_q : wr.addr;
	assign wdata = busy_q ? '0 : wr.data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && $past(busy_q) && $past(arst_n) |-> clr_addr_q == addr_t'($past(clr_addr_q) + 1'b1))
		else $error("clear sweep skipped an entry");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !wr.en)
		else $error("pipeline write during clear sweep");

endmodule

@@ rtl/sfe_mac.sv @@
module sfe_mac
	import sfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              accept,
	input  sample_t           x_re,
	input  sample_t           x_im,
	input  bin_tag_t          tag,
	input  logic [GAIN_W-1:0] gain,
	input  logic [PAIR_W-1:0] rdata_s1,
	output logic              push,
	output result_t           result,
	output store_wr_t         wr
);

	localparam int PROD_W  = GAIN_W + SAMPLE_BITS + 1;
	localparam int ACC_W   = PROD_W + 1;
	localparam int FRAC_W  = GAIN_W;
	localparam int SUM_W   = ACC_W - FRAC_W;
	localparam int ROUND_C = 1 << (FRAC_W - 1);

	// Stage 1: history word (or forwarded sum) times gain.
	logic              v_s1;
	sample_t           x_re_s1, x_im_s1;
	bin_tag_t          tag_s1;
	logic              fwd_hit_s1;
	logic [PAIR_W-1:0] fwd_s1;

	// Stage 2: round, add the input bin, saturate, write back.
	logic                     v_s2;
	sample_t                  x_re_s2, x_im_s2;
	bin_tag_t                 tag_s2;
	logic signed [PROD_W-1:0] prod_re_s2, prod_im_s2;

	sample_t                  h_re, h_im;
	logic signed [PROD_W-1:0] gain_ext, prod_re, prod_im;
	logic signed [ACC_W-1:0]  acc_re, acc_im;
	logic [SAMPLE_BITS:0]     sat_re, sat_im;

	function automatic logic [SAMPLE_BITS:0] saturate(input logic [SUM_W-1:0] v);
		logic [SUM_W-SAMPLE_BITS:0] hi_bits;
		logic [SAMPLE_BITS:0]       r;
		hi_bits = v[SUM_W-1:SAMPLE_BITS-1];
		if (&hi_bits || ~|hi_bits) begin
			r = {1'b0, v[SAMPLE_BITS-1:0]};
		end else if (v[SUM_W-1]) begin
			r = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			r = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	// The memory read misses only the write of the item leaving stage 2 in the
	// same cycle; bins two apart may share an address, so that sum is forwarded.
	assign h_re     = fwd_hit_s1 ? sample_t'(fwd_s1[SAMPLE_BITS-1:0])
	                             : sample_t'(rdata_s1[SAMPLE_BITS-1:0]);
	assign h_im     = fwd_hit_s1 ? sample_t'(fwd_s1[PAIR_W-1:SAMPLE_BITS])
	                             : sample_t'(rdata_s1[PAIR_W-1:SAMPLE_BITS]);
	assign gain_ext = PROD_W'($signed({1'b0, gain}));
	assign prod_re  = gain_ext * PROD_W'(h_re);
	assign prod_im  = gain_ext * PROD_W'(h_im);

	// x + round(p / 2^16) folded into one add before the shift.
	assign acc_re = (ACC_W'(x_re_s2) <<< FRAC_W) + ACC_W'(prod_re_s2) + ACC_W'(ROUND_C);
	assign acc_im = (ACC_W'(x_im_s2) <<< FRAC_W) + ACC_W'(prod_im_s2) + ACC_W'(ROUND_C);
	assign sat_re = saturate(acc_re[ACC_W-1:FRAC_W]);
	assign sat_im = saturate(acc_im[ACC_W-1:FRAC_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (accept) begin
				x_re_s1    <= x_re;
				x_im_s1    <= x_im;
				tag_s1     <= tag;
				fwd_hit_s1 <= v_s2 && (tag_s2.addr == tag.addr);
				fwd_s1     <= {sat_im[SAMPLE_BITS-1:0], sat_re[SAMPLE_BITS-1:0]};
			end
			x_re_s2    <= x_re_s1;
			x_im_s2    <= x_im_s1;
			tag_s2     <= tag_s1;
			prod_re_s2 <= prod_re;
			prod_im_s2 <= prod_im;
		end
	end

	assign push        = advance && v_s2;
	assign result.re   = sample_t'(sat_re[SAMPLE_BITS-1:0]);
	assign result.im   = sample_t'(sat_im[SAMPLE_BITS-1:0]);
	assign result.last = tag_s2.last;
	assign result.clip = sat_re[SAMPLE_BITS] || sat_im[SAMPLE_BITS];
	assign wr.en       = push;
	assign wr.addr     = tag_s2.addr;
	assign wr.data     = {sat_im[SAMPLE_BITS-1:0], sat_re[SAMPLE_BITS-1:0]};

	a_neighbors_differ: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> tag_s1.addr != tag_s2.addr)
		else $error("adjacent bins share a history address");

endmodule

@@ rtl/sfe_out_buf.sv @@
module sfe_out_buf
	import sfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  result_t            result,
	output logic               full,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast,
	output logic               m_axis_tuser
);

	logic    v_s3;
	result_t result_s3;
	logic    skid_v_q;
	result_t skid_q;

	// The skid entry catches the one beat that leaves stage 2 in the cycle the
	// output stalls; its fill then holds the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3     <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (v_s3 && !m_axis_tready) begin
				skid_v_q <= 1'b1;
			end else begin
				v_s3 <= 1'b1;
			end
		end else if (m_axis_tready) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) begin
				result_s3 <= skid_q;
			end
		end else if (push) begin
			if (v_s3 && !m_axis_tready) begin
				skid_q <= result;
			end else begin
				result_s3 <= result;
			end
		end
	end

	assign full          = skid_v_q;
	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = TDATA_W'({result_s3.im, result_s3.re});
	assign m_axis_tlast  = result_s3.last;
	assign m_axis_tuser  = result_s3.clip;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> v_s3)
		else $error("skid entry held without an output beat");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !push)
		else $error("beat pushed into a full output buffer");

endmodule

@@ rtl/spectral_feedback_echo.sv @@
// Per-bin feedback comb filter on a stream of complex spectral frames. Each bin
// beat is added to the gain-scaled output of the same bin from delay_frames
// frames earlier, saturated to 24 bits (tuser flags a clip) and fed back into
// the history. One bin is taken every cycle while the output buffer is not full
// and the history sweep is done. An accepted beat passes stage 1 and stage 2
// before it reaches the output register. A two-entry output buffer keeps
// m_axis_tready off the path to s_axis_tready. While a beat waits in the output
// register, the next beat from the pipeline fills the second entry, and
// s_axis_tready drops in the following cycle. The history is a 16384 x 48-bit
// single-port-write memory that is swept to zero after reset: s_axis_tready
// stays low until the sweep is done. Configuration (gain, delay, bin count) is
// to be written only while no beats are in flight; a write resets nothing else.
module spectral_feedback_echo
	import sfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TDATA_W-1:0]    s_axis_tdata,   // bin_real, bin_imag
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TDATA_W-1:0]    m_axis_tdata,   // out_real, out_imag
	output logic                  m_axis_tlast,   // frame_end
	output logic                  m_axis_tuser,   // clipped
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              accept;
	logic              advance;
	logic              out_full;
	logic              clear_busy;
	logic [GAIN_W-1:0] gain;
	bin_tag_t          tag;
	logic [PAIR_W-1:0] rdata_s1;
	logic              push;
	result_t           result;
	store_wr_t         wr;
	sample_t           x_re, x_im;

	assign advance       = !out_full;
	assign s_axis_tready = advance && !clear_busy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign x_re          = sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign x_im          = sample_t'(s_axis_tdata[PAIR_W-1:SAMPLE_BITS]);

	sfe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.gain      (gain),
		.tag       (tag)
	);

	sfe_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (tag.addr),
		.rdata_s1 (rdata_s1),
		.wr       (wr),
		.busy     (clear_busy)
	);

	sfe_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.accept   (accept),
		.x_re     (x_re),
		.x_im     (x_im),
		.tag      (tag),
		.gain     (gain),
		.rdata_s1 (rdata_s1),
		.push     (push),
		.result   (result),
		.wr       (wr)
	);

	sfe_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.result        (result),
		.full          (out_full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ test/spectral_feedback_echo_tb.sv @@
`timescale 1ns / 100ps

module spectral_feedback_echo_tb;
	import sfe_pkg::*;

	localparam int STORE_DEPTH   = MAX_DELAY * MAX_BINS;
	localparam int SETTLE_CYCLES = 16;
	localparam int WIDE_BINS     = 800;
	localparam int RANDOM_BINS   = 560;

	// Index 3 maps to no register; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct {
		sample_t re;
		sample_t im;
	} bin_pair_t;

	typedef struct {
		sample_t re;
		sample_t im;
		logic    last;
		logic    clip;
	} echo_bin_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bin_pair_t  pending_bins[$];
	echo_bin_t  expected_echoes[$];
	reg_write_t reg_writes[$];

	// Shadow of the block: register values, history and frame position.
	logic [GAIN_W-1:0]      gain_cfg;
	logic [DELAY_CFG_W-1:0] delay_cfg;
	logic [BINS_CFG_W-1:0]  bins_cfg;
	sample_t                echo_hist_re [STORE_DEPTH];
	sample_t                echo_hist_im [STORE_DEPTH];
	int                     next_bin;
	int                     hist_slot;

	int          burst_left;
	int          gap_left;
	stall_mode_e stall_mode;
	int          stall_left;
	logic [7:0]  stall_tick;

	int failures;
	int results_checked;
	int frame_ends;
	int clips_seen;
	int cfg_writes;
	int phases_run;

	spectral_feedback_echo i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gain times stored sample, rounded to nearest with ties toward plus infinity.
	function automatic longint scaled_echo(logic [GAIN_W-1:0] gain, sample_t held);
		longint p;
		p = longint'({1'b0, gain}) * longint'(held) + 64'sd32768;
		return p >>> 16;
	endfunction

	function automatic sample_t clamp_sample(input longint v, inout logic clip);
		if (v > longint'(SAMPLE_MAX)) begin
			clip = 1'b1;
			return SAMPLE_MAX;
		end
		if (v < longint'(SAMPLE_MIN)) begin
			clip = 1'b1;
			return SAMPLE_MIN;
		end
		return sample_t'(v);
	endfunction

	function automatic echo_bin_t predict_echo(sample_t x_re, sample_t x_im);
		echo_bin_t r;
		int        bins_eff;
		int        delay_eff;
		int        addr;
		logic      clip;
		bins_eff  = (bins_cfg < 2) ? 2 : (bins_cfg > MAX_BINS) ? MAX_BINS : int'(bins_cfg);
		delay_eff = (delay_cfg < 1) ? 1 :
			(delay_cfg > MAX_DELAY) ? MAX_DELAY : int'(delay_cfg);
		addr = hist_slot * MAX_BINS + next_bin;
		clip = 1'b0;
		r.re = clamp_sample(longint'(x_re) + scaled_echo(gain_cfg, echo_hist_re[addr]), clip);
		r.im = clamp_sample(longint'(x_im) + scaled_echo(gain_cfg, echo_hist_im[addr]), clip);
		r.clip = clip;
		echo_hist_re[addr] = r.re;
		echo_hist_im[addr] = r.im;
		// A shrunken bin count or delay closes the frame or slot at once.
		r.last = (next_bin >= bins_eff - 1);
		if (r.last) begin
			next_bin  = 0;
			hist_slot = (hist_slot >= delay_eff - 1) ? 0 : hist_slot + 1;
		end else begin
			next_bin = next_bin + 1;
		end
		return r;
	endfunction

	function automatic sample_t pick_sample(bit loud);
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
			default: begin
				// Loud values sit in the outer quarters of the range.
				if (loud)
					return sample_t'({2'($urandom_range(1, 2)), 22'($urandom)});
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic queue_bin(sample_t re, sample_t im);
		bin_pair_t b;
		b.re = re;
		b.im = im;
		pending_bins.insert(pending_bins.size(), b);
	endtask

	task automatic queue_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		reg_write_t w;
		w.index = index;
		w.data  = data;
		reg_writes.insert(reg_writes.size(), w);
	endtask

	// Waits until no beat or register write is in flight, then lets the pipeline settle.
	task automatic drain();
		while (pending_bins.size() != 0 || s_axis_tvalid || expected_echoes.size() != 0 ||
			reg_writes.size() != 0 || cfg_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		phases_run++;
	endtask

	always @(posedge clk or negedge arst_n) begin : cfg_side
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= REG_ECHO_GAIN;
			cfg_data  <= '0;
			gain_cfg   = GAIN_W'(GAIN_RESET);
			delay_cfg  = DELAY_CFG_W'(DELAY_RESET);
			bins_cfg   = BINS_CFG_W'(BINS_RESET);
			cfg_writes = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ECHO_GAIN:    gain_cfg  = cfg_data[GAIN_W-1:0];
					REG_DELAY_FRAMES: delay_cfg = cfg_data[DELAY_CFG_W-1:0];
					REG_BINS_IN_USE:  bins_cfg  = cfg_data[BINS_CFG_W-1:0];
					default: ;
				endcase
				cfg_writes++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					w = reg_writes.pop_front();
					cfg_index <= w.index;
					cfg_data  <= w.data;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : bin_side
		bin_pair_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left    <= 0;
			gap_left      <= 0;
			for (int a = 0; a < STORE_DEPTH; a++) begin
				echo_hist_re[a] = '0;
				echo_hist_im[a] = '0;
			end
			next_bin  = 0;
			hist_slot = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_echoes.insert(expected_echoes.size(),
					predict_echo(sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]),
					sample_t'(s_axis_tdata[PAIR_W-1:SAMPLE_BITS])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left      <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bins.size() != 0) begin
					nxt = pending_bins.pop_front();
					s_axis_tdata  <= TDATA_W'({nxt.im, nxt.re});
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) :
							$urandom_range(1, 16);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_side
		echo_bin_t want;
		sample_t   got_re;
		sample_t   got_im;
		if (!arst_n) begin
			m_axis_tready   <= 1'b0;
			stall_mode      <= STALL_NONE;
			stall_left      <= 0;
			stall_tick      <= '0;
			failures        = 0;
			results_checked = 0;
			frame_ends      = 0;
			clips_seen      = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_re = sample_t'(m_axis_tdata[SAMPLE_BITS-1:0]);
				got_im = sample_t'(m_axis_tdata[PAIR_W-1:SAMPLE_BITS]);
				if (expected_echoes.size() == 0) begin
					$error("Result beat with nothing expected: out_real %0d, out_imag %0d",
						got_re, got_im);
					failures++;
				end else begin
					want = expected_echoes.pop_front();
					if (got_re !== want.re) begin
						$error("out_real: expected %0d, got %0d", want.re, got_re);
						failures++;
					end
					if (got_im !== want.im) begin
						$error("out_imag: expected %0d, got %0d", want.im, got_im);
						failures++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("frame_end: expected %0b, got %0b", want.last, m_axis_tlast);
						failures++;
					end
					if (m_axis_tuser !== want.clip) begin
						$error("clipped: expected %0b, got %0b", want.clip, m_axis_tuser);
						failures++;
					end
					results_checked++;
				end
				if (m_axis_tlast)
					frame_ends++;
				if (m_axis_tuser)
					clips_seen++;
			end
			stall_tick <= stall_tick + 1'b1;
			if (stall_left == 0) begin
				stall_mode <= stall_mode_e'($urandom_range(0, 3));
				stall_left <= $urandom_range(16, 160);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE:  m_axis_tready <= 1'b1;
				STALL_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
				STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 5) == 0);
				default:     m_axis_tready <= (stall_tick[2:0] != 3'd5) && (stall_tick[2:0] != 3'd6);
			endcase
		end
	end

	initial begin : stimulus
		sample_t corners[7];
		int      random_sent;
		int      phase_len;
		int      v;
		bit      loud;
		phases_run = 0;
		corners[0] = SAMPLE_MAX;
		corners[1] = SAMPLE_MIN;
		corners[2] = '0;
		corners[3] = sample_t'(1);
		corners[4] = sample_t'(-1);
		corners[5] = sample_t'(24'h555555);
		corners[6] = sample_t'(24'hAAAAAA);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Full gain, delay and bin count below range, plus a write to the unmapped index.
		queue_reg(REG_ECHO_GAIN, 16'hFFFF);
		queue_reg(REG_DELAY_FRAMES, 16'hFFC0);
		queue_reg(REG_BINS_IN_USE, 16'hFC01);
		queue_reg(REG_UNMAPPED, 16'hA5A5);
		drain();
		queue_bin(SAMPLE_MAX, SAMPLE_MAX);
		queue_bin(SAMPLE_MIN, SAMPLE_MIN);
		queue_bin(SAMPLE_MAX, SAMPLE_MIN);
		queue_bin('0, '0);
		queue_bin(SAMPLE_MAX, SAMPLE_MAX);
		queue_bin(SAMPLE_MIN, SAMPLE_MIN);
		queue_bin(sample_t'(1), sample_t'(-1));
		queue_bin(sample_t'(-1), sample_t'(1));
		queue_bin(SAMPLE_MIN, SAMPLE_MAX);
		queue_bin('0, '0);
		drain();

		// Stop part way into the third slot of a five-bin, three-frame history.
		queue_reg(REG_ECHO_GAIN, 16'h8000);
		queue_reg(REG_DELAY_FRAMES, 16'h0003);
		queue_reg(REG_BINS_IN_USE, 16'h0005);
		drain();
		for (int k = 0; k < 12; k++)
			queue_bin(corners[k % 7], corners[6 - (k % 7)]);
		drain();

		// Shrinking both sizes now must close the frame and wrap the slot on the next beat.
		queue_reg(REG_DELAY_FRAMES, 16'h0002);
		queue_reg(REG_BINS_IN_USE, 16'h0002);
		drain();
		queue_bin(SAMPLE_MAX, '0);
		queue_bin('0, SAMPLE_MIN);
		queue_bin(SAMPLE_MIN, SAMPLE_MAX);
		drain();

		// Full-width frames with a one-frame delay so the upper bins see their echo.
		queue_reg(REG_ECHO_GAIN, GAIN_W'(GAIN_RESET));
		queue_reg(REG_DELAY_FRAMES, 16'h0001);
		queue_reg(REG_BINS_IN_USE, 16'h03FF);
		drain();
		for (int k = 0; k < WIDE_BINS; k++)
			queue_bin(pick_sample(1'b0), pick_sample(1'b0));
		drain();

		random_sent = 0;
		while (random_sent < RANDOM_BINS) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0:       queue_reg(REG_ECHO_GAIN, '0);
					1:       queue_reg(REG_ECHO_GAIN, 16'hFFFF);
					2:       queue_reg(REG_ECHO_GAIN, GAIN_W'(GAIN_RESET));
					default: queue_reg(REG_ECHO_GAIN, 16'($urandom));
				endcase
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0:       v = 0;
					1:       v = MAX_DELAY;
					2:       v = $urandom_range(MAX_DELAY + 1, 63);
					3:       v = $urandom_range(0, 63);
					default: v = $urandom_range(1, 4);
				endcase
				queue_reg(REG_DELAY_FRAMES, (16'($urandom) & ~16'h003F) | 16'(v));
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 11))
					0:       v = $urandom_range(0, 1);
					1:       v = MAX_BINS;
					2:       v = $urandom_range(MAX_BINS + 1, 1023);
					3:       v = $urandom_range(13, 64);
					default: v = $urandom_range(2, 12);
				endcase
				queue_reg(REG_BINS_IN_USE, (16'($urandom) & ~16'h03FF) | 16'(v));
			end
			if ($urandom_range(0, 7) == 0)
				queue_reg(REG_UNMAPPED, 16'($urandom));
			drain();
			loud      = ($urandom_range(0, 2) == 0);
			phase_len = $urandom_range(10, 120);
			for (int k = 0; k < phase_len; k++)
				queue_bin(pick_sample(loud), pick_sample(loud));
			random_sent += phase_len;
			drain();
		end

		$display("Checked %0d bin beats: %0d frame ends, %0d clipped, over %0d idle points.",
			results_checked, frame_ends, clips_seen, phases_run);
		$display("Register writes accepted: %0d, out-of-range and unmapped ones included.",
			cfg_writes);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("Run did not finish in time; %0d results still expected.",
			expected_echoes.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
